FILE: hdl/bdb_pkg.sv
`timescale 1ns / 1ps
// Package for the B-spline De Boor evaluator.
// Holds default sizes, item and status codes, sequencer states and shared types.
package bdb_pkg;

	localparam int BDB_MAX_CONTROLS = 64;
	localparam int BDB_MAX_KNOTS    = 128;
	localparam int BDB_MAX_DEGREE   = 7;
	localparam int BDB_FRAC_BITS    = 16;

	localparam logic [6:0] CTRL_COUNT_RESET = 7'd4;
	localparam logic [7:0] KNOT_COUNT_RESET = 8'd8;

	localparam logic REG_CC = 1'b0;
	localparam logic REG_KC = 1'b1;

	typedef enum logic [1:0] {
		KIND_CTRL = 2'd0,
		KIND_KNOT = 2'd1,
		KIND_EVAL = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SPAN     = 2'd1,
		ST_DEGREE   = 2'd2,
		ST_ZERO_DEN = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SPAN_CHK,
		S_LOAD_RD,
		S_LOAD_WR,
		S_BL_RD1,
		S_BL_RD2,
		S_BL_DEN,
		S_BL_DIV,
		S_BL_WA,
		S_BL_WB,
		S_BL_WC,
		S_BL_MUL,
		S_BL_ACC,
		S_BL_WR,
		S_OUT_RD,
		S_OUT_CAP,
		S_FIN
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: hdl/bspline_de_boor_evaluator.sv
`timescale 1ns / 1ps
// Top level of the B-spline De Boor evaluator; uses bdb_pkg, bdb_ram and bdb_div.
// A load transfer is written in the cycle it is accepted. An evaluation spends most
// of its time in the shared divider, which finds one quotient bit per cycle.
// One item is in work at a time. Reset sets the counts to 4 and 8 and idles the sequencer;
// the tables are not cleared.
module bspline_de_boor_evaluator
	import bdb_pkg::*;
#(
	parameter int MAX_CONTROLS = BDB_MAX_CONTROLS,
	parameter int MAX_KNOTS    = BDB_MAX_KNOTS,
	parameter int MAX_DEGREE   = BDB_MAX_DEGREE,
	parameter int FRAC_BITS    = BDB_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [6:0]         index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic signed [31:0] knot_value,
	input  logic signed [31:0] param_t,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic [1:0]         status
);

	localparam int CAW  = $clog2(MAX_CONTROLS);
	localparam int KAW  = $clog2(MAX_KNOTS);
	localparam int WAW  = $clog2(MAX_DEGREE + 1);
	localparam int KB   = $clog2(MAX_KNOTS + 1);
	localparam int CW   = (KB > 8 ? KB : 8) + 2;
	localparam int NUMW = 33 + FRAC_BITS;
	localparam int DENW = 33;

	state_t state_q, state_d;

	logic [6:0]  cc_q;
	logic [7:0]  kc_q;
	logic        out_valid_q;
	logic [31:0] px_q, py_q, pz_q;
	status_t     ost_q;

	logic signed [31:0] t_q;
	logic [WAW-1:0]     p_q;
	logic [WAW-1:0]     j_q;
	logic [WAW-1:0]     r_q;
	logic [1:0]         c_q;
	logic [CW-1:0]      k_q;
	logic [CW-1:0]      s_q;
	logic [CW-1:0]      base_q;
	logic signed [31:0] ki_q;
	logic signed [31:0] alpha_q;
	logic [95:0]        a_q;
	logic [95:0]        b_q;
	logic [95:0]        res_q;
	logic signed [64:0] prod_q;
	status_t            stat_q;

	logic           accept;
	logic           cfg_wr;
	logic           cp_we, kn_we;
	logic [CAW-1:0] cp_raddr;
	logic [95:0]    cp_rdata;
	logic [KAW-1:0] kn_raddr;
	logic [31:0]    kn_rdata;
	logic           work_we;
	logic [WAW-1:0] work_waddr;
	logic [95:0]    work_wdata;
	logic [WAW-1:0] work_raddr;
	logic [95:0]    work_rdata;

	logic signed [9:0]    p_full;
	logic                 cfg_bad;
	logic signed [31:0]   kv;
	logic                 srch_last;
	logic signed [CW-1:0] span_w;
	logic                 span_bad;
	logic [CW-1:0]        idx_i;
	logic [CW-1:0]        kd_idx;
	logic signed [32:0]   num_diff;
	logic signed [32:0]   den_diff;
	logic [32:0]          num_mag;
	logic [32:0]          den_mag;
	logic                 div_start;
	div_stat_t            div_stat;
	logic signed [31:0]   div_quot;
	logic signed [31:0]   a_c, b_c;
	logic signed [64:0]   alpha_w, diff_w;
	logic signed [65:0]   sum_w;
	logic [31:0]          sat_w;
	logic                 out_load;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_KC) ? {24'b0, kc_q} : {25'b0, cc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= CTRL_COUNT_RESET;
			kc_q <= KNOT_COUNT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_KC) begin
				kc_q <= pwdata[7:0];
			end else begin
				cc_q <= pwdata[6:0];
			end
		end
	end

	// Tables.
	assign accept = in_valid && in_ready;
	assign cp_we  = accept && (kind == KIND_CTRL) && ({25'b0, index} < 32'(MAX_CONTROLS));
	assign kn_we  = accept && (kind == KIND_KNOT) && ({25'b0, index} < 32'(MAX_KNOTS));

	bdb_ram #(.WIDTH(96), .DEPTH(MAX_CONTROLS)) u_cp_ram (
		.clk   (clk),
		.we    (cp_we),
		.waddr (CAW'(index)),
		.wdata ({coord_z, coord_y, coord_x}),
		.raddr (cp_raddr),
		.rdata (cp_rdata)
	);

	bdb_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_knot_ram (
		.clk   (clk),
		.we    (kn_we),
		.waddr (KAW'(index)),
		.wdata (knot_value),
		.raddr (kn_raddr),
		.rdata (kn_rdata)
	);

	bdb_ram #(.WIDTH(96), .DEPTH(MAX_DEGREE + 1)) u_work_ram (
		.clk   (clk),
		.we    (work_we),
		.waddr (work_waddr),
		.wdata (work_wdata),
		.raddr (work_raddr),
		.rdata (work_rdata)
	);

	// Weight divider.
	assign num_diff = 33'(t_q) - 33'(ki_q);
	assign den_diff = 33'($signed(kn_rdata)) - 33'(ki_q);
	assign num_mag  = num_diff[32] ? 33'(-num_diff) : 33'(num_diff);
	assign den_mag  = den_diff[32] ? 33'(-den_diff) : 33'(den_diff);

	bdb_div #(.NUMW(NUMW), .DENW(DENW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({num_mag, {FRAC_BITS{1'b0}}}),
		.divisor  (den_mag),
		.negate   (num_diff[32] ^ den_diff[32]),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	// Shared combinational terms.
	assign p_full = $signed({2'b0, kc_q}) - $signed({3'b0, cc_q}) - 10'sd1;
	assign cfg_bad = (cc_q == 7'd0) || ({25'b0, cc_q} > 32'(MAX_CONTROLS)) ||
		(kc_q < 8'd2) || ({24'b0, kc_q} > 32'(MAX_KNOTS)) ||
		(p_full < 10'sd0) || (p_full > $signed(10'(MAX_DEGREE)));
	assign kv        = $signed(kn_rdata);
	assign srch_last = (k_q + 1'b1) == CW'(kc_q);
	assign span_w    = $signed(k_q) - $signed(CW'(1)) -
		((k_q != s_q) ? $signed(s_q) : $signed(CW'(0)));
	assign span_bad  = (span_w < $signed(CW'(p_q))) ||
		(span_w > ($signed(CW'(cc_q)) - $signed(CW'(1))));
	assign idx_i     = base_q + CW'(j_q);
	assign kd_idx    = idx_i + CW'(p_q) + CW'(1) - CW'(r_q);

	assign a_c     = $signed(a_q[32*c_q +: 32]);
	assign b_c     = $signed(b_q[32*c_q +: 32]);
	assign alpha_w = 65'(alpha_q);
	assign diff_w  = 65'(b_c) - 65'(a_c);
	assign sum_w   = 66'(prod_q >>> FRAC_BITS) + 66'(a_c);
	assign sat_w   = (sum_w[65:31] == '0 || sum_w[65:31] == '1) ? sum_w[31:0] :
		(sum_w[65] ? 32'h8000_0000 : 32'h7FFF_FFFF);

	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		div_start  = 1'b0;
		work_we    = 1'b0;
		work_waddr = j_q;
		work_wdata = res_q;
		work_raddr = j_q;
		cp_raddr   = CAW'(idx_i);
		kn_raddr   = KAW'(idx_i);
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && kind == KIND_EVAL) begin
					state_d = cfg_bad ? S_FIN : S_SRCH_RD;
				end
			end
			S_SRCH_RD: begin
				kn_raddr = KAW'(k_q);
				state_d  = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				state_d = (t_q < kv || srch_last) ? S_SPAN_CHK : S_SRCH_RD;
			end
			S_SPAN_CHK: begin
				state_d = span_bad ? S_FIN : S_LOAD_RD;
			end
			S_LOAD_RD: begin
				state_d = S_LOAD_WR;
			end
			S_LOAD_WR: begin
				work_we    = 1'b1;
				work_wdata = cp_rdata;
				if (j_q == p_q) begin
					state_d = (p_q == '0) ? S_OUT_RD : S_BL_RD1;
				end else begin
					state_d = S_LOAD_RD;
				end
			end
			S_BL_RD1: begin
				state_d = S_BL_RD2;
			end
			S_BL_RD2: begin
				kn_raddr = KAW'(kd_idx);
				state_d  = S_BL_DEN;
			end
			S_BL_DEN: begin
				if (den_diff == '0) begin
					state_d = S_FIN;
				end else begin
					div_start = 1'b1;
					state_d   = S_BL_DIV;
				end
			end
			S_BL_DIV: begin
				if (div_stat.done) begin
					state_d = S_BL_WA;
				end
			end
			S_BL_WA: begin
				work_raddr = j_q - 1'b1;
				state_d    = S_BL_WB;
			end
			S_BL_WB: begin
				state_d = S_BL_WC;
			end
			S_BL_WC: begin
				state_d = S_BL_MUL;
			end
			S_BL_MUL: begin
				state_d = S_BL_ACC;
			end
			S_BL_ACC: begin
				state_d = (c_q == 2'd2) ? S_BL_WR : S_BL_MUL;
			end
			S_BL_WR: begin
				work_we = 1'b1;
				if (j_q == r_q && r_q == p_q) begin
					state_d = S_OUT_RD;
				end else begin
					state_d = S_BL_RD1;
				end
			end
			S_OUT_RD: begin
				work_raddr = p_q;
				state_d    = S_OUT_CAP;
			end
			S_OUT_CAP: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				t_q    <= param_t;
				k_q    <= '0;
				s_q    <= '0;
				p_q    <= WAW'(p_full);
				stat_q <= cfg_bad ? ST_DEGREE : ST_OK;
			end
			S_SRCH_CMP: begin
				if (t_q == kv) begin
					s_q <= s_q + 1'b1;
				end
				if (!(t_q < kv)) begin
					k_q <= k_q + 1'b1;
				end
			end
			S_SPAN_CHK: begin
				base_q <= CW'(span_w) - CW'(p_q);
				j_q    <= '0;
				if (span_bad) begin
					stat_q <= ST_SPAN;
				end
			end
			S_LOAD_WR: begin
				if (j_q == p_q) begin
					j_q <= p_q;
					r_q <= WAW'(1);
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			S_BL_RD2: begin
				ki_q <= kv;
			end
			S_BL_DEN: begin
				if (den_diff == '0) begin
					stat_q <= ST_ZERO_DEN;
				end
			end
			S_BL_DIV: begin
				alpha_q <= div_quot;
			end
			S_BL_WB: begin
				a_q <= work_rdata;
			end
			S_BL_WC: begin
				b_q <= work_rdata;
				c_q <= 2'd0;
			end
			S_BL_MUL: begin
				prod_q <= alpha_w * diff_w;
			end
			S_BL_ACC: begin
				res_q[32*c_q +: 32] <= sat_w;
				c_q <= c_q + 1'b1;
			end
			S_BL_WR: begin
				if (j_q == r_q) begin
					r_q <= r_q + 1'b1;
					j_q <= p_q;
				end else begin
					j_q <= j_q - 1'b1;
				end
			end
			S_OUT_CAP: begin
				res_q <= work_rdata;
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ost_q <= stat_q;
			px_q  <= (stat_q == ST_OK) ? res_q[31:0] : 32'h0;
			py_q  <= (stat_q == ST_OK) ? res_q[63:32] : 32'h0;
			pz_q  <= (stat_q == ST_OK) ? res_q[95:64] : 32'h0;
		end
	end

	assign out_valid = out_valid_q;
	assign point_x   = $signed(px_q);
	assign point_y   = $signed(py_q);
	assign point_z   = $signed(pz_q);
	assign status    = ost_q;

	// Checks.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> point_x == 0 && point_y == 0 && point_z == 0)
		else $error("failed evaluation carries a nonzero point");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_work_addr: assert property (@(posedge clk) disable iff (!arst_n)
		work_we |-> work_waddr <= p_q)
		else $error("work point written beyond the degree");

	a_hold_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ready)
		else $error("transfer taken while an evaluation is in work");

endmodule

FILE: hdl/bdb_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module bdb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/bdb_div.sv
`timescale 1ns / 1ps
// Restoring divider for the blend weights, one quotient bit per cycle.
// Depends on bdb_pkg; the signed quotient is saturated to 32 bits.
module bdb_div
	import bdb_pkg::*;
#(
	parameter int NUMW = 49,
	parameter int DENW = 33
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [NUMW-1:0]        dividend,
	input  logic [DENW-1:0]        divisor,
	input  logic                   negate,
	output div_stat_t              stat,
	output logic signed [31:0]     quotient
);

	localparam int CNTW = $clog2(NUMW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [NUMW-1:0] q_q;
	logic [DENW-1:0] r_q;
	logic [DENW-1:0] d_q;
	logic            neg_q;
	logic [DENW:0]   trial;
	logic            fits;
	logic            hi;

	assign trial = {r_q, q_q[NUMW-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NUMW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			r_q   <= '0;
			d_q   <= divisor;
			neg_q <= negate;
		end else if (busy_q) begin
			r_q <= fits ? DENW'(trial - {1'b0, d_q}) : trial[DENW-1:0];
			q_q <= {q_q[NUMW-2:0], fits};
		end
	end

	assign hi = |q_q[NUMW-1:32];

	always_comb begin
		if (neg_q) begin
			if (hi || (q_q[31] && |q_q[30:0])) begin
				quotient = 32'sh8000_0000;
			end else begin
				quotient = -$signed(q_q[31:0]);
			end
		end else begin
			if (hi || q_q[31]) begin
				quotient = 32'sh7FFF_FFFF;
			end else begin
				quotient = $signed(q_q[31:0]);
			end
		end
	end

	assign stat = '{busy: busy_q, done: done_q};

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for bspline_de_boor_evaluator: evaluation results are checked
// against a local De Boor predictor that tracks loads and register writes. Uses bdb_pkg.
module tb_top;
	import bdb_pkg::*;

	typedef struct {
		kind_t       kind;
		logic [6:0]  index;
		logic [31:0] cx, cy, cz, knot, t;
	} load_item_t;

	typedef struct {
		logic [31:0] x, y, z;
		status_t     st;
	} point_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0, in_ready;
	logic [1:0] kind = 0;
	logic [6:0] index = 0;
	logic signed [31:0] coord_x = 0, coord_y = 0, coord_z = 0, knot_value = 0, param_t = 0;
	logic out_valid, out_ready = 0;
	logic signed [31:0] point_x, point_y, point_z;
	logic [1:0] status;

	bspline_de_boor_evaluator dut (.*);

	always #4 clk = ~clk;

	load_item_t pending_items[$];
	point_res_t expected_points[$];
	int errors = 0;

	int signed ctrl_x[64], ctrl_y[64], ctrl_z[64];
	int signed knots[128];
	int unsigned ctrl_cnt = 4, knot_cnt = 8;
	int signed gen_knots[128];

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic point_res_t de_boor_point(int signed t);
		point_res_t res;
		longint p, k, s, span, num, den, alpha, a, b, i;
		longint wp[8][3];
		res.x = 0;
		res.y = 0;
		res.z = 0;
		res.st = ST_OK;
		if (ctrl_cnt < 1 || ctrl_cnt > 64 || knot_cnt < 2 || knot_cnt > 128) begin
			res.st = ST_DEGREE;
			return res;
		end
		p = longint'(knot_cnt) - longint'(ctrl_cnt) - 1;
		if (p < 0 || p > 7) begin
			res.st = ST_DEGREE;
			return res;
		end
		s = 0;
		for (k = 0; k < knot_cnt; k++) begin
			if (t == knots[k]) s++;
			else if (t < knots[k]) break;
		end
		span = k - 1 - ((k != s) ? s : 0);
		if (span < p || span > longint'(ctrl_cnt) - 1) begin
			res.st = ST_SPAN;
			return res;
		end
		for (longint r = 1; r <= p; r++)
			for (longint j = span - p + r; j <= span; j++)
				if (knots[j + p + 1 - r] == knots[j]) begin
					res.st = ST_ZERO_DEN;
					return res;
				end
		for (longint j = 0; j <= p; j++) begin
			wp[j][0] = ctrl_x[span - p + j];
			wp[j][1] = ctrl_y[span - p + j];
			wp[j][2] = ctrl_z[span - p + j];
		end
		for (longint r = 1; r <= p; r++)
			for (longint j = p; j >= r; j--) begin
				i = span - p + j;
				num = (longint'(t) - longint'(knots[i])) * 65536;
				den = longint'(knots[i + p + 1 - r]) - longint'(knots[i]);
				alpha = sat32(num / den);
				for (int c = 0; c < 3; c++) begin
					a = wp[j - 1][c];
					b = wp[j][c];
					wp[j][c] = sat32(a + ((alpha * (b - a)) >>> 16));
				end
			end
		res.x = wp[p][0][31:0];
		res.y = wp[p][1][31:0];
		res.z = wp[p][2][31:0];
		return res;
	endfunction

	// Input side: apply accepted load transfers to the local tables and queue a predicted point for each evaluation.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			case (kind_t'(kind))
				KIND_CTRL: if (index < 64) begin
					ctrl_x[index] = coord_x;
					ctrl_y[index] = coord_y;
					ctrl_z[index] = coord_z;
				end
				KIND_KNOT: knots[index] = knot_value;
				KIND_EVAL: expected_points.push_back(de_boor_point(param_t));
				default: ;
			endcase
		end
	end

	int burst_left = 0, gap_left = 0;
	load_item_t cur;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 0;
			end else if (pending_items.size() > 0) begin
				cur = pending_items.pop_front();
				kind <= cur.kind;
				index <= cur.index;
				coord_x <= cur.cx;
				coord_y <= cur.cy;
				coord_z <= cur.cz;
				knot_value <= cur.knot;
				param_t <= cur.t;
				in_valid <= 1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 0;
			end
		end
	end

	int stall_phase = 0;
	point_res_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					report("unexpected result", point_x, 0);
				end else begin
					want = expected_points.pop_front();
					if (point_x !== want.x) report("point_x", point_x, want.x);
					if (point_y !== want.y) report("point_y", point_y, want.y);
					if (point_z !== want.z) report("point_z", point_z, want.z);
					if (status !== want.st) report("status", status, want.st);
				end
			end
			stall_phase = (stall_phase + 1) % 1500;
			if (stall_phase < 500) out_ready <= 1;
			else if (stall_phase < 1000) out_ready <= ($urandom_range(0, 3) != 0);
			else out_ready <= ($urandom_range(0, 7) == 0);
		end
	end

	task automatic push_item(kind_t k, logic [6:0] idx, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [31:0] kv, logic [31:0] t);
		load_item_t it;
		it.kind = k;
		it.index = idx;
		it.cx = x;
		it.cy = y;
		it.cz = z;
		it.knot = kv;
		it.t = t;
		pending_items.push_back(it);
	endtask

	task automatic push_ctrl(int idx);
		push_item(KIND_CTRL, idx, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic push_knot(int idx, int signed v);
		if (idx < 128) gen_knots[idx] = v;
		push_item(KIND_KNOT, idx, $urandom, $urandom, $urandom, v, $urandom);
	endtask

	task automatic push_eval(int signed t);
		push_item(KIND_EVAL, $urandom, $urandom, $urandom, $urandom, $urandom, t);
	endtask

	task automatic sorted_knots(int n, bit dups);
		int signed v;
		v = $urandom_range(0, 40) * 65536 - 20 * 65536 + $urandom_range(0, 65535);
		for (int i = 0; i < n; i++) begin
			push_knot(i, v);
			if (!dups || $urandom_range(0, 5) != 0)
				v += $urandom_range(1, 3 * 65536);
		end
	endtask

	function automatic int signed pick_t(int lo, int hi);
		int signed a, b;
		a = gen_knots[lo];
		b = gen_knots[hi];
		case ($urandom_range(0, 9))
			0: return gen_knots[$urandom_range(lo, hi)];
			1: return $urandom;
			2: return a - $urandom_range(0, 65536);
			3: return b + $urandom_range(0, 65536);
			default: return (b > a) ? a + int'($urandom_range(0, b - a)) : a;
		endcase
	endfunction

	task automatic wait_idle(int extra);
		while (pending_items.size() != 0 || in_valid || expected_points.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		if (addr == 3'd0) ctrl_cnt = data[6:0];
		else knot_cnt = data[7:0];
	endtask

	task automatic run_phase(int cc, int kc, int n, bit dups);
		int p, lo, hi;
		wait_idle(20);
		reg_write(3'd0, cc);
		reg_write(3'd4, kc);
		p = kc - cc - 1;
		lo = (p >= 0 && p < 128) ? p : 0;
		hi = (cc < 128) ? cc : 127;
		if (cc >= 1 && cc <= 64 && p >= 0 && p <= 7)
			sorted_knots((kc > 128) ? 128 : kc, dups);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 19))
				0, 1, 2: push_ctrl($urandom_range(0, 127));
				3: push_knot($urandom_range(0, 127), $urandom);
				4: push_item(KIND_NONE, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom);
				5: push_knot($urandom_range(kc < 128 ? kc : 0, 127), $urandom);
				default: push_eval(pick_t(lo, hi));
			endcase
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		for (int i = 0; i < 64; i++) push_ctrl(i);
		sorted_knots(8, 0);
		push_item(KIND_CTRL, 0, 32'h7fffffff, 32'h80000000, 32'h0, 0, 0);
		push_item(KIND_CTRL, 3, 32'h80000000, 32'h7fffffff, 32'hffffffff, 0, 0);
		push_item(KIND_CTRL, 7'd100, 32'h12345678, 0, 0, 0, 0);
		push_eval(32'h80000000);
		push_eval(32'h7fffffff);
		push_eval(gen_knots[3]);
		push_eval(gen_knots[4]);
		push_eval(gen_knots[0]);
		push_eval(gen_knots[7]);
		push_eval(gen_knots[3] + 1);
		push_eval((gen_knots[3] + gen_knots[4]) / 2);
		push_knot(4, gen_knots[3]);
		push_knot(5, gen_knots[3]);
		push_eval(gen_knots[3]);
		push_eval(gen_knots[3] - 1);
		push_item(KIND_NONE, 7'h7f, 32'hffffffff, 32'hffffffff, 32'hffffffff,
				32'hffffffff, 32'hffffffff);
		sorted_knots(8, 0);
		for (int i = 0; i < 60; i++) push_eval(pick_t(3, 4));
		run_phase(1, 2, 30, 0);
		run_phase(8, 11, 60, 1);
		run_phase(5, 9, 60, 1);
		run_phase(64, 72, 15, 0);
		run_phase(0, 8, 20, 0);
		run_phase(64, 128, 20, 0);
		run_phase(10, 5, 20, 0);
		run_phase(127, 255, 20, 0);
		run_phase(3, 6, 60, 0);
		run_phase(6, 10, 60, 1);
		run_phase(20, 22, 50, 0);
		wait_idle(2200);
		if (errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

	initial begin
		#30000000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: bspline_de_boor_evaluator.f
hdl/bdb_pkg.sv
hdl/bdb_ram.sv
hdl/bdb_div.sv
hdl/bspline_de_boor_evaluator.sv
verif/tb_top.sv
